### rtl/core/qatu_pkg.sv
// Package: shared constants and types for the quaternion box transform core.
`default_nettype none
package qatu_pkg;
    localparam int IN_AXIS_WIDTH_DEF  = 16;
    localparam int OUT_AXIS_WIDTH_DEF = 20;
    localparam int QUAT_WIDTH         = 16;
    localparam int QUAT_PROD_WIDTH    = 2 * QUAT_WIDTH;
    localparam int MAT_FULL_WIDTH     = 35;
    localparam int MAT_FRAC_DROP      = 14;
    localparam int M_WIDTH            = MAT_FULL_WIDTH - MAT_FRAC_DROP;
    localparam int CORNER_FRAC_DROP   = 22;
    localparam int NUM_CORNERS        = 8;
    localparam int NUM_AXES           = 3;
    localparam int NUM_MAT            = 9;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;
endpackage
`default_nettype wire

### rtl/core/qatu_if.sv
// Interfaces: part input channel and box result channel.
`default_nettype none
interface qatu_in_if #(parameter int IN_AXIS_WIDTH = 16);
    logic                       valid;
    logic                       ready;
    logic [3*IN_AXIS_WIDTH-1:0] local_min_xyz;
    logic [3*IN_AXIS_WIDTH-1:0] local_max_xyz;
    logic [63:0]                rotation_quat;
    logic [3*IN_AXIS_WIDTH-1:0] scale_xyz;
    logic [3*IN_AXIS_WIDTH-1:0] position_xyz;
    logic                       last_part;
    modport source (output valid, local_min_xyz, local_max_xyz, rotation_quat,
                    scale_xyz, position_xyz, last_part, input ready);
    modport sink   (input valid, local_min_xyz, local_max_xyz, rotation_quat,
                    scale_xyz, position_xyz, last_part, output ready);
endinterface

interface qatu_out_if #(parameter int OUT_AXIS_WIDTH = 20);
    logic                        valid;
    logic                        ready;
    logic [3*OUT_AXIS_WIDTH-1:0] part_min_xyz;
    logic [3*OUT_AXIS_WIDTH-1:0] part_max_xyz;
    logic [3*OUT_AXIS_WIDTH-1:0] union_min_xyz;
    logic [3*OUT_AXIS_WIDTH-1:0] union_max_xyz;
    logic                        group_done;
    modport source (output valid, part_min_xyz, part_max_xyz, union_min_xyz,
                    union_max_xyz, group_done, input ready);
    modport sink   (input valid, part_min_xyz, part_max_xyz, union_min_xyz,
                    union_max_xyz, group_done, output ready);
endinterface
`default_nettype wire

### rtl/core/qatu_setup.sv
// Setup stages: quaternion products, rotation matrix and scaled box bounds.
`default_nettype none
module qatu_setup import qatu_pkg::*; #(
    parameter int IN_AXIS_WIDTH = IN_AXIS_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire t_ctl                            i_ctl,
    input  wire logic [3*IN_AXIS_WIDTH-1:0]      i_local_min_xyz,
    input  wire logic [3*IN_AXIS_WIDTH-1:0]      i_local_max_xyz,
    input  wire logic [63:0]                     i_rotation_quat,
    input  wire logic [3*IN_AXIS_WIDTH-1:0]      i_scale_xyz,
    input  wire logic [3*IN_AXIS_WIDTH-1:0]      i_position_xyz,
    output t_ctl                                 o_ctl,
    output logic signed [M_WIDTH-1:0]            o_m   [NUM_MAT],
    output logic signed [2*IN_AXIS_WIDTH-1:0]    o_slo [NUM_AXES],
    output logic signed [2*IN_AXIS_WIDTH-1:0]    o_shi [NUM_AXES],
    output logic signed [IN_AXIS_WIDTH-1:0]      o_pos [NUM_AXES]
);
    localparam int W  = IN_AXIS_WIDTH;
    localparam int FW = MAT_FULL_WIDTH;

    logic signed [QUAT_WIDTH-1:0]      w_q [4];
    logic signed [QUAT_PROD_WIDTH-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [2*W-1:0]             r_slo1 [NUM_AXES];
    logic signed [2*W-1:0]             r_shi1 [NUM_AXES];
    logic signed [W-1:0]               r_pos1 [NUM_AXES];
    t_ctl                              r_ctl1, r_ctl2;
    logic signed [FW-1:0]              n_full [NUM_MAT];
    logic signed [FW-1:0]              w_rnd  [NUM_MAT];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_q[k] = $signed(i_rotation_quat[k*QUAT_WIDTH +: QUAT_WIDTH]);
        end
    end

    // Stage one: quaternion products and scaled bounds
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= w_q[0] * w_q[0];
            r_yy <= w_q[1] * w_q[1];
            r_zz <= w_q[2] * w_q[2];
            r_xy <= w_q[0] * w_q[1];
            r_xz <= w_q[0] * w_q[2];
            r_yz <= w_q[1] * w_q[2];
            r_wx <= w_q[3] * w_q[0];
            r_wy <= w_q[3] * w_q[1];
            r_wz <= w_q[3] * w_q[2];
            for (int a = 0; a < NUM_AXES; a++) begin
                r_slo1[a] <= $signed(i_local_min_xyz[a*W +: W]) * $signed(i_scale_xyz[a*W +: W]);
                r_shi1[a] <= $signed(i_local_max_xyz[a*W +: W]) * $signed(i_scale_xyz[a*W +: W]);
                r_pos1[a] <= $signed(i_position_xyz[a*W +: W]);
            end
        end
    end

    // Form matrix entries exactly, then round to Q.14
    always_comb begin
        n_full[0] = (FW'(1) <<< 28) - 2 * (FW'(r_yy) + FW'(r_zz));
        n_full[1] = 2 * (FW'(r_xy) - FW'(r_wz));
        n_full[2] = 2 * (FW'(r_xz) + FW'(r_wy));
        n_full[3] = 2 * (FW'(r_xy) + FW'(r_wz));
        n_full[4] = (FW'(1) <<< 28) - 2 * (FW'(r_xx) + FW'(r_zz));
        n_full[5] = 2 * (FW'(r_yz) - FW'(r_wx));
        n_full[6] = 2 * (FW'(r_xz) - FW'(r_wy));
        n_full[7] = 2 * (FW'(r_yz) + FW'(r_wx));
        n_full[8] = (FW'(1) <<< 28) - 2 * (FW'(r_xx) + FW'(r_yy));
        for (int k = 0; k < NUM_MAT; k++) begin
            w_rnd[k] = n_full[k] + (FW'(1) <<< (MAT_FRAC_DROP - 1));
        end
    end

    // Stage two: hold matrix and pass bounds along
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_MAT; k++) begin
                o_m[k] <= $signed(w_rnd[k][MAT_FRAC_DROP +: M_WIDTH]);
            end
            for (int a = 0; a < NUM_AXES; a++) begin
                o_slo[a] <= r_slo1[a];
                o_shi[a] <= r_shi1[a];
                o_pos[a] <= r_pos1[a];
            end
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_en) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    assign o_ctl = r_ctl2;
endmodule
`default_nettype wire

### rtl/core/qatu_corner_lane.sv
// Corner lane: rotate, round, translate and saturate one box corner.
`default_nettype none
module qatu_corner_lane import qatu_pkg::*; #(
    parameter int IN_AXIS_WIDTH  = IN_AXIS_WIDTH_DEF,
    parameter int OUT_AXIS_WIDTH = OUT_AXIS_WIDTH_DEF,
    parameter int CORNER         = 0
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic signed [M_WIDTH-1:0]       i_m   [NUM_MAT],
    input  wire logic signed [2*IN_AXIS_WIDTH-1:0] i_slo [NUM_AXES],
    input  wire logic signed [2*IN_AXIS_WIDTH-1:0] i_shi [NUM_AXES],
    input  wire logic signed [IN_AXIS_WIDTH-1:0] i_pos [NUM_AXES],
    output logic signed [OUT_AXIS_WIDTH-1:0]     o_v   [NUM_AXES]
);
    localparam int W   = IN_AXIS_WIDTH;
    localparam int O   = OUT_AXIS_WIDTH;
    localparam int PW  = 2*W + M_WIDTH;
    localparam int AW  = PW + 2;
    localparam int TW  = AW - CORNER_FRAC_DROP;
    localparam int XW  = ((TW + 1) > O ? (TW + 1) : O) + 1;

    logic signed [2*W-1:0] w_s [NUM_AXES];
    logic signed [PW-1:0]  r_p [NUM_MAT];
    logic signed [W-1:0]   r_pos [NUM_AXES];
    logic signed [AW-1:0]  w_acc [NUM_AXES];
    logic signed [XW-1:0]  w_x   [NUM_AXES];
    logic signed [XW-1:0]  w_hi, w_lo;

    // Pick the corner bounds
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_s[a] = ((CORNER >> a) & 1) != 0 ? i_shi[a] : i_slo[a];
        end
    end

    // Stage one: matrix times corner
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    r_p[r*NUM_AXES + a] <= i_m[r*NUM_AXES + a] * w_s[a];
                end
                r_pos[r] <= i_pos[r];
            end
        end
    end

    // Sum rows, round to Q.8, translate and saturate
    always_comb begin
        w_hi = (XW'(1) <<< (O - 1)) - XW'(1);
        w_lo = -w_hi - XW'(1);
        for (int r = 0; r < NUM_AXES; r++) begin
            w_acc[r] = AW'(r_p[r*NUM_AXES]) + AW'(r_p[r*NUM_AXES + 1])
                     + AW'(r_p[r*NUM_AXES + 2]) + (AW'(1) <<< (CORNER_FRAC_DROP - 1));
            w_x[r]   = XW'($signed(w_acc[r][CORNER_FRAC_DROP +: TW])) + XW'(r_pos[r]);
        end
    end

    // Stage two: hold the saturated corner
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < NUM_AXES; r++) begin
                if (w_x[r] > w_hi) begin
                    o_v[r] <= w_hi[O-1:0];
                end else if (w_x[r] < w_lo) begin
                    o_v[r] <= w_lo[O-1:0];
                end else begin
                    o_v[r] <= w_x[r][O-1:0];
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/core/qatu_merge.sv
// Merge stage: part box over the corner lanes, running union and result register.
`default_nettype none
module qatu_merge import qatu_pkg::*; #(
    parameter int OUT_AXIS_WIDTH = OUT_AXIS_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire t_ctl                              i_ctl,
    input  wire logic signed [OUT_AXIS_WIDTH-1:0]  i_v [NUM_CORNERS][NUM_AXES],
    output logic                                   o_valid,
    output logic [3*OUT_AXIS_WIDTH-1:0]            o_part_min,
    output logic [3*OUT_AXIS_WIDTH-1:0]            o_part_max,
    output logic [3*OUT_AXIS_WIDTH-1:0]            o_union_min,
    output logic [3*OUT_AXIS_WIDTH-1:0]            o_union_max,
    output logic                                   o_done
);
    localparam int O = OUT_AXIS_WIDTH;

    logic signed [O-1:0] n_pmin [NUM_AXES];
    logic signed [O-1:0] n_pmax [NUM_AXES];
    logic signed [O-1:0] r_pmin [NUM_AXES];
    logic signed [O-1:0] r_pmax [NUM_AXES];
    logic signed [O-1:0] r_umin [NUM_AXES];
    logic signed [O-1:0] r_umax [NUM_AXES];
    logic signed [O-1:0] n_umin [NUM_AXES];
    logic signed [O-1:0] n_umax [NUM_AXES];
    t_ctl                r_ctl;
    logic                r_acc_valid;
    logic                r_out_valid;
    logic                r_done;
    logic                w_load;

    // Min and max over the eight corners
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            n_pmin[a] = i_v[0][a];
            n_pmax[a] = i_v[0][a];
            for (int c = 1; c < NUM_CORNERS; c++) begin
                if (i_v[c][a] < n_pmin[a]) n_pmin[a] = i_v[c][a];
                if (i_v[c][a] > n_pmax[a]) n_pmax[a] = i_v[c][a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pmin <= n_pmin;
            r_pmax <= n_pmax;
        end
    end

    // Fold the part into the union
    assign w_load = i_en && r_ctl.valid;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (r_acc_valid && r_umin[a] < r_pmin[a]) n_umin[a] = r_umin[a];
            else                                      n_umin[a] = r_pmin[a];
            if (r_acc_valid && r_umax[a] > r_pmax[a]) n_umax[a] = r_umax[a];
            else                                      n_umax[a] = r_pmax[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_umin <= n_umin;
            r_umax <= n_umax;
            r_done <= r_ctl.last;
            for (int a = 0; a < NUM_AXES; a++) begin
                o_part_min[a*O +: O] <= r_pmin[a];
                o_part_max[a*O +: O] <= r_pmax[a];
            end
        end
    end

    // Advance control and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_out_valid <= 1'b0;
            r_acc_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_ctl       <= i_ctl;
                r_out_valid <= r_ctl.valid;
            end
            if (w_load) begin
                r_acc_valid <= !r_ctl.last;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            o_union_min[a*O +: O] = r_umin[a];
            o_union_max[a*O +: O] = r_umax[a];
        end
    end

    assign o_valid = r_out_valid;
    assign o_done  = r_done;

    // Last part closes the group
    a_group_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_ctl.last) |=> !r_acc_valid)
        else $error("group not closed after last part");

    // First part of a group loads the union
    a_group_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_acc_valid) |=>
        (r_umin[0] == $signed(o_part_min[O-1:0]) && r_umax[0] == $signed(o_part_max[O-1:0])))
        else $error("union not loaded from first part");

    // Union encloses the part on the first axis
    a_union_encloses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_umin[0] <= $signed(o_part_min[O-1:0])
                      && r_umax[0] >= $signed(o_part_max[O-1:0])))
        else $error("union does not enclose part");
endmodule
`default_nettype wire

### rtl/core/quaternion_aabb_transform_union_core.sv
// Top level: quaternion box transform with running union over part groups.
// Each part enters as one transaction and leaves as one result transaction; a new
// part is taken every cycle while the result side keeps up.
// Two setup stages build the rotation matrix and the scaled bounds, eight corner
// lanes rotate, translate and saturate in two stages, and a merge stage takes the
// part box and then the group union. The whole pipeline holds when a result waits.
`default_nettype none
module quaternion_aabb_transform_union_core import qatu_pkg::*; #(
    parameter int IN_AXIS_WIDTH  = IN_AXIS_WIDTH_DEF,
    parameter int OUT_AXIS_WIDTH = OUT_AXIS_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qatu_in_if.sink   i_in,
    qatu_out_if.source o_out
);
    localparam int W = IN_AXIS_WIDTH;
    localparam int O = OUT_AXIS_WIDTH;

    logic                  w_en;
    t_ctl                  w_ctl_in, w_ctl2;
    t_ctl                  r_ctl3, r_ctl4;
    logic signed [M_WIDTH-1:0] w_m   [NUM_MAT];
    logic signed [2*W-1:0] w_slo [NUM_AXES];
    logic signed [2*W-1:0] w_shi [NUM_AXES];
    logic signed [W-1:0]   w_pos [NUM_AXES];
    logic signed [W-1:0]   r_pos3 [NUM_AXES];
    logic signed [O-1:0]   w_v [NUM_CORNERS][NUM_AXES];

    // Advance whenever the result register is free
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;
    assign w_ctl_in   = '{valid: i_in.valid, last: i_in.last_part};

    qatu_setup #(.IN_AXIS_WIDTH(W)) u_setup (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_ctl           (w_ctl_in),
        .i_local_min_xyz (i_in.local_min_xyz),
        .i_local_max_xyz (i_in.local_max_xyz),
        .i_rotation_quat (i_in.rotation_quat),
        .i_scale_xyz     (i_in.scale_xyz),
        .i_position_xyz  (i_in.position_xyz),
        .o_ctl           (w_ctl2),
        .o_m             (w_m),
        .o_slo           (w_slo),
        .o_shi           (w_shi),
        .o_pos           (w_pos)
    );

    // Hold a copy of the setup position; only the position assertion reads it
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pos3 <= w_pos;
        end
    end

    for (genvar c = 0; c < NUM_CORNERS; c++) begin : g_lane
        qatu_corner_lane #(
            .IN_AXIS_WIDTH  (W),
            .OUT_AXIS_WIDTH (O),
            .CORNER         (c)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_m   (w_m),
            .i_slo (w_slo),
            .i_shi (w_shi),
            .i_pos (w_pos),
            .o_v   (w_v[c])
        );
    end

    // Track control across the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
            r_ctl4 <= '0;
        end else if (w_en) begin
            r_ctl3 <= w_ctl2;
            r_ctl4 <= r_ctl3;
        end
    end

    qatu_merge #(.OUT_AXIS_WIDTH(O)) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (r_ctl4),
        .i_v         (w_v),
        .o_valid     (o_out.valid),
        .o_part_min  (o_out.part_min_xyz),
        .o_part_max  (o_out.part_max_xyz),
        .o_union_min (o_out.union_min_xyz),
        .o_union_max (o_out.union_max_xyz),
        .o_done      (o_out.group_done)
    );

    // Lane position copy must follow the setup output
    a_pos_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |=> (r_pos3[0] == $past(w_pos[0])))
        else $error("position copy lost");
endmodule
`default_nettype wire

### test/testbench.sv
// Testbench for the quaternion box transform core with running group union.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qatu_pkg::*;

    localparam int IW = IN_AXIS_WIDTH_DEF;
    localparam int OW = OUT_AXIS_WIDTH_DEF;

    typedef struct packed {
        logic [3*IW-1:0] lo;
        logic [3*IW-1:0] hi;
        logic [63:0]     quat;
        logic [3*IW-1:0] scale;
        logic [3*IW-1:0] pos;
        logic            last;
    } t_part;

    typedef struct packed {
        logic [3*OW-1:0] pmin;
        logic [3*OW-1:0] pmax;
        logic [3*OW-1:0] umin;
        logic [3*OW-1:0] umax;
        logic            done;
    } t_box;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    qatu_in_if  #(.IN_AXIS_WIDTH(IW))  in_if ();
    qatu_out_if #(.OUT_AXIS_WIDTH(OW)) out_if ();

    quaternion_aabb_transform_union_core #(
        .IN_AXIS_WIDTH(IW),
        .OUT_AXIS_WIDTH(OW)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    always #6 i_clk = ~i_clk;

    // Predicted union state
    logic [3*OW-1:0] union_lo, union_hi;
    logic            union_open;
    t_box            box_queue[$];
    int              error_count = 0;
    logic            stall_mode = 1'b0;
    logic            idle_mode = 1'b0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR %s got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic longint sx(input logic [63:0] w, input int at, input int wd);
        longint v;
        v = (w >> at) & ((64'd1 << wd) - 1);
        if (v[wd-1]) v = v - (longint'(1) << wd);
        return v;
    endfunction

    function automatic longint floor_rnd(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Transform one part and fold it into the running union
    function automatic t_box transform_part(input t_part p);
        longint q[4], m[3][3], sc[3], lo[3], hi[3], ps[3], s[3];
        longint wmin[3], wmax[3], v, acc, lim;
        t_box b;
        lim = (longint'(1) << (OW - 1)) - 1;
        for (int a = 0; a < 4; a++) q[a] = sx(p.quat, 16 * a, 16);
        for (int a = 0; a < 3; a++) begin
            lo[a] = sx(p.lo, IW * a, IW);
            hi[a] = sx(p.hi, IW * a, IW);
            sc[a] = sx(p.scale, IW * a, IW);
            ps[a] = sx(p.pos, IW * a, IW);
        end
        m[0][0] = (longint'(1) << 28) - 2 * (q[1] * q[1] + q[2] * q[2]);
        m[0][1] = 2 * (q[0] * q[1] - q[3] * q[2]);
        m[0][2] = 2 * (q[0] * q[2] + q[3] * q[1]);
        m[1][0] = 2 * (q[0] * q[1] + q[3] * q[2]);
        m[1][1] = (longint'(1) << 28) - 2 * (q[0] * q[0] + q[2] * q[2]);
        m[1][2] = 2 * (q[1] * q[2] - q[3] * q[0]);
        m[2][0] = 2 * (q[0] * q[2] - q[3] * q[1]);
        m[2][1] = 2 * (q[1] * q[2] + q[3] * q[0]);
        m[2][2] = (longint'(1) << 28) - 2 * (q[0] * q[0] + q[1] * q[1]);
        for (int r = 0; r < 3; r++)
            for (int a = 0; a < 3; a++) m[r][a] = floor_rnd(m[r][a], 14);
        for (int c = 0; c < 8; c++) begin
            for (int a = 0; a < 3; a++) s[a] = (((c >> a) & 1) ? hi[a] : lo[a]) * sc[a];
            for (int r = 0; r < 3; r++) begin
                acc = m[r][0] * s[0] + m[r][1] * s[1] + m[r][2] * s[2];
                v = floor_rnd(acc, 22) + ps[r];
                if (v > lim) v = lim;
                if (v < -lim - 1) v = -lim - 1;
                if (c == 0 || v < wmin[r]) wmin[r] = v;
                if (c == 0 || v > wmax[r]) wmax[r] = v;
            end
        end
        for (int a = 0; a < 3; a++) begin
            b.pmin[OW*a +: OW] = wmin[a][OW-1:0];
            b.pmax[OW*a +: OW] = wmax[a][OW-1:0];
            if (union_open) begin
                if (wmin[a] < sx(union_lo, OW * a, OW)) union_lo[OW*a +: OW] = wmin[a][OW-1:0];
                if (wmax[a] > sx(union_hi, OW * a, OW)) union_hi[OW*a +: OW] = wmax[a][OW-1:0];
            end else begin
                union_lo[OW*a +: OW] = wmin[a][OW-1:0];
                union_hi[OW*a +: OW] = wmax[a][OW-1:0];
            end
        end
        b.umin = union_lo;
        b.umax = union_hi;
        b.done = p.last;
        union_open = !p.last;
        return b;
    endfunction

    // Send one part, idling between bursts
    task automatic send_part(input t_part p);
        if (idle_mode && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        {in_if.local_min_xyz, in_if.local_max_xyz, in_if.rotation_quat,
         in_if.scale_xyz, in_if.position_xyz, in_if.last_part} <= p;
        do @(posedge i_clk); while (!in_if.ready);
        box_queue.insert(box_queue.size(), transform_part(p));
    endtask

    function automatic logic [3*IW-1:0] pack3(input int x, input int y, input int z);
        return {z[IW-1:0], y[IW-1:0], x[IW-1:0]};
    endfunction

    function automatic t_part random_part();
        t_part p;
        int k;
        logic [9*32-1:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom};
        p = raw[$bits(t_part)-1:0];
        k = $urandom_range(0, 3);
        if (k != 0) begin
            // mostly well-formed: bounded quaternion components, modest sizes
            p.quat = {16'($urandom_range(0, 32767) - 16384), 16'($urandom_range(0, 32767) - 16384),
                      16'($urandom_range(0, 32767) - 16384), 16'($urandom_range(0, 32767) - 16384)};
            p.lo = pack3($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                         $urandom_range(0, 4095) - 2048);
            p.hi = pack3($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
            p.scale = pack3($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
        end
        p.last = ($urandom_range(0, 4) == 0);
        return p;
    endfunction

    task automatic drain();
        in_if.valid <= 1'b0;
        while (box_queue.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_part p;
        p = '0;
        p.quat = 64'h4000_0000_0000_0000;
        p.scale = pack3(256, 256, 256);
        p.lo = pack3(-256, -512, -768);
        p.hi = pack3(256, 512, 768);
        send_part(p);
        p.lo = {3{16'h7fff}}; p.hi = {3{16'h8000}}; p.scale = {3{16'h7fff}};
        send_part(p);
        p.scale = {3{16'h8000}}; p.pos = {3{16'h7fff}};
        send_part(p);
        p.pos = {3{16'h8000}}; p.last = 1'b1;
        send_part(p);
        p = '1;
        send_part(p);
        p.quat = 64'h8000_8000_8000_8000; p.last = 1'b0;
        send_part(p);
        p.quat = 64'h2d41_0000_2d41_0000; p.lo = '0; p.hi = pack3(512, 256, 128);
        p.scale = pack3(256, 512, 256); p.pos = pack3(100, -100, 5); p.last = 1'b1;
        send_part(p);
        p.quat = 64'h7fff_7fff_7fff_7fff; p.last = 1'b1;
        send_part(p);
    endtask

    task automatic test_random_stream();
        idle_mode = 1'b1;
        stall_mode = 1'b1;
        for (int i = 0; i < 400; i++) begin
            send_part(random_part());
            // hold off until every result has come back
            if (i == 200) drain();
        end
    endtask

    // Receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) out_if.ready <= 1'b0;
        else out_if.ready <= !stall_mode || ($urandom_range(0, 7) > 2);
    end

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_box got, want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.part_min_xyz, out_if.part_max_xyz, out_if.union_min_xyz,
                   out_if.union_max_xyz, out_if.group_done};
            if (box_queue.size() == 0) begin
                report("unexpected result", 64'(got.pmin), 64'd0);
            end else begin
                want = box_queue.pop_front();
                if (got.pmin !== want.pmin)
                    report("part_min_xyz", 64'(got.pmin), 64'(want.pmin));
                if (got.pmax !== want.pmax)
                    report("part_max_xyz", 64'(got.pmax), 64'(want.pmax));
                if (got.umin !== want.umin)
                    report("union_min_xyz", 64'(got.umin), 64'(want.umin));
                if (got.umax !== want.umax)
                    report("union_max_xyz", 64'(got.umax), 64'(want.umax));
                if (got.done !== want.done)
                    report("group_done", 64'(got.done), 64'(want.done));
            end
        end
    end

    initial begin
        in_if.valid <= 1'b0;
        {in_if.local_min_xyz, in_if.local_max_xyz, in_if.rotation_quat,
         in_if.scale_xyz, in_if.position_xyz, in_if.last_part} <= '0;
        union_lo = '0; union_hi = '0; union_open = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_stream();
        drain();
        if (error_count == 0) $display("quaternion_aabb_transform_union_core: match");
        else $display("quaternion_aabb_transform_union_core: mismatch");
        $finish;
    end

    initial begin
        #2ms;
        $display("quaternion_aabb_transform_union_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
